// ===== rtl/logfmt_pair_tokenizer_defines.svh =====
// Assertion helpers for the tokenizer checker.
`ifndef LOGFMT_PAIR_TOKENIZER_DEFINES_SVH
`define LOGFMT_PAIR_TOKENIZER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define LPT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define LPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

// ===== rtl/lpt_pkg.sv =====
package lpt_pkg;

   localparam int COUNT_WIDTH = 16;
   // pair counter saturates at 16 bits or at its own width if narrower
   localparam int CNT_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

   // power of two, pointers wrap on their own
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   localparam logic [3:0] WM_START = 4'd0;
   localparam logic [3:0] WM_TRUE = 4'd4;
   localparam logic [3:0] WM_FALSE_FIRST = 4'd5;
   localparam logic [3:0] WM_FALSE = 4'd9;
   localparam logic [3:0] WM_NONE = 4'd15;

   localparam logic [2:0] VT_STRING = 3'd0;
   localparam logic [2:0] VT_INTEGER = 3'd1;
   localparam logic [2:0] VT_FLOAT = 3'd2;
   localparam logic [2:0] VT_TRUE = 3'd3;
   localparam logic [2:0] VT_FALSE = 3'd4;

   typedef enum logic [2:0] {
      KIND_KEY   = 3'd0,
      KIND_VAL   = 3'd1,
      KIND_PAIR  = 3'd2,
      KIND_ABORT = 3'd3,
      KIND_LINE  = 3'd4
   } kind_type;

   typedef enum logic [6:0] {
      PH_BETWEEN  = 7'b0000001,
      PH_KEY      = 7'b0000010,
      PH_VSTART   = 7'b0000100,
      PH_UNQUOTED = 7'b0001000,
      PH_QUOTED   = 7'b0010000,
      PH_QESC     = 7'b0100000,
      PH_SKIP     = 7'b1000000
   } phase_type;

   typedef enum logic [7:0] {
      NP_START = 8'b00000001,
      NP_SIGN  = 8'b00000010,
      NP_INT   = 8'b00000100,
      NP_FRAC  = 8'b00001000,
      NP_EXPM  = 8'b00010000,
      NP_EXPS  = 8'b00100000,
      NP_EXPD  = 8'b01000000,
      NP_NOT   = 8'b10000000
   } num_phase_type;

   // one queue entry: the results of one input item
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [2:0]  vtype;
      logic [63:0] ival;
      logic [15:0] count;
      logic        two;   // a line end result follows the first one
   } rec_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   // expected byte at each position of "true" / "false"
   function automatic logic [7:0] word_char(input logic [3:0] wm);
      logic [7:0] r;
      case (wm)
         4'd1: r = 8'h72;
         4'd2: r = 8'h75;
         4'd3: r = 8'h65;
         4'd5: r = 8'h61;
         4'd6: r = 8'h6C;
         4'd7: r = 8'h73;
         4'd8: r = 8'h65;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/lpt_front.sv =====
module lpt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_ch,
   input  logic             in_line_end,
   output logic             push,
   output lpt_pkg::rec_type push_rec,
   input  logic             full
);
   import lpt_pkg::*;

   phase_type     phase_ff, phase_in;
   num_phase_type np_ff, np_in;
   logic [3:0]    wm_ff, wm_in;
   logic [63:0]   acc_ff, acc_in;
   logic          neg_ff, neg_in;
   logic          sat_ff, sat_in;
   logic          te_ff, te_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // value tracking for the current byte
   num_phase_type tv_np;
   logic [3:0]    tv_wm;
   logic [63:0]   tv_acc;
   logic          tv_neg;
   logic          tv_sat;
   logic          do_acc;
   logic [67:0]   prod;
   logic [67:0]   lim;

   logic [2:0]    pe_type;
   logic [63:0]   pe_ival;
   logic [CNT_W-1:0] cnt_inc;

   logic [7:0]    c;
   logic          sp;
   logic          take;

   assign c = in_ch;
   assign sp = is_space(in_ch);
   assign in_ready = !full;
   assign take = in_valid && !full;

   // a digit never changes the sign, so the stored sign picks the limit
   assign lim = {4'b0, neg_ff, {63{!neg_ff}}};
   assign prod = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {64'b0, c[3:0]};
   assign cnt_inc = (cnt_ff == {CNT_W{1'b1}}) ? cnt_ff : cnt_ff + 1'b1;

   always_comb begin
      tv_np = NP_NOT;
      tv_neg = neg_ff;
      do_acc = 1'b0;
      case (np_ff)
         NP_START: begin
            if (c == CH_MINUS) begin
               tv_neg = 1'b1;
               tv_np = NP_SIGN;
            end else if (is_digit(c)) begin
               do_acc = 1'b1;
               tv_np = NP_INT;
            end
         end
         NP_SIGN: begin
            if (is_digit(c)) begin
               do_acc = 1'b1;
               tv_np = NP_INT;
            end
         end
         NP_INT: begin
            if (is_digit(c)) begin
               do_acc = 1'b1;
               tv_np = NP_INT;
            end else if (c == CH_DOT) begin
               tv_np = NP_FRAC;
            end else if (c == CH_LOWER_E || c == CH_UPPER_E) begin
               tv_np = NP_EXPM;
            end
         end
         NP_FRAC: begin
            if (c == CH_LOWER_E || c == CH_UPPER_E) begin
               tv_np = NP_EXPM;
            end else if (is_digit(c)) begin
               tv_np = NP_FRAC;
            end
         end
         NP_EXPM: begin
            if (c == CH_PLUS || c == CH_MINUS) begin
               tv_np = NP_EXPS;
            end else if (is_digit(c)) begin
               tv_np = NP_EXPD;
            end
         end
         NP_EXPS, NP_EXPD: begin
            if (is_digit(c)) begin
               tv_np = NP_EXPD;
            end
         end
         default: tv_np = NP_NOT;
      endcase

      // saturate once the next decimal step would pass the limit of its sign
      tv_acc = acc_ff;
      tv_sat = sat_ff;
      if (do_acc && !sat_ff) begin
         if (prod > lim) begin
            tv_acc = lim[63:0];
            tv_sat = 1'b1;
         end else begin
            tv_acc = prod[63:0];
         end
      end

      if (wm_ff == WM_START) begin
         tv_wm = (c == CH_LOWER_T) ? 4'd1 : (c == CH_LOWER_F) ? WM_FALSE_FIRST : WM_NONE;
      end else if ((wm_ff >= 4'd1 && wm_ff <= 4'd3) || (wm_ff >= 4'd5 && wm_ff <= 4'd8)) begin
         tv_wm = (c == word_char(wm_ff)) ? wm_ff + 4'd1 : WM_NONE;
      end else begin
         tv_wm = WM_NONE;
      end
   end

   // classification at pair end uses the stored value state
   always_comb begin
      pe_type = VT_STRING;
      pe_ival = 64'd0;
      if (np_ff == NP_INT) begin
         pe_type = VT_INTEGER;
         pe_ival = neg_ff ? (64'd0 - acc_ff) : acc_ff;
      end else if (np_ff == NP_FRAC || np_ff == NP_EXPD) begin
         pe_type = VT_FLOAT;
      end else if (wm_ff == WM_TRUE) begin
         pe_type = VT_TRUE;
      end else if (wm_ff == WM_FALSE) begin
         pe_type = VT_FALSE;
      end
   end

   always_comb begin
      logic clear_v;
      logic track;
      logic pair;
      clear_v = 1'b0;
      track = 1'b0;
      pair = 1'b0;
      phase_in = phase_ff;
      te_in = te_ff;
      cnt_in = cnt_ff;
      push = 1'b0;
      push_rec.kind = KIND_KEY;
      push_rec.data = 8'd0;
      push_rec.vtype = VT_STRING;
      push_rec.ival = 64'd0;
      push_rec.count = 16'd0;
      push_rec.two = 1'b0;

      if (take) begin
         if (in_line_end || c == 8'd0) begin
            push = 1'b1;
            case (phase_ff)
               PH_KEY, PH_QUOTED, PH_QESC: begin
                  if (te_ff) begin
                     push_rec.kind = KIND_ABORT;
                     push_rec.two = 1'b1;
                  end
                  push_rec.count = 16'(cnt_ff);
               end
               PH_VSTART, PH_UNQUOTED: begin
                  push_rec.kind = KIND_PAIR;
                  push_rec.vtype = pe_type;
                  push_rec.ival = pe_ival;
                  push_rec.two = 1'b1;
                  push_rec.count = 16'(cnt_inc);
               end
               default: push_rec.count = 16'(cnt_ff);
            endcase
            if (!push_rec.two) begin
               push_rec.kind = KIND_LINE;
            end
            // back to reset state for the next line
            phase_in = PH_BETWEEN;
            te_in = 1'b0;
            cnt_in = '0;
            clear_v = 1'b1;
         end else begin
            case (phase_ff)
               PH_KEY: begin
                  if (c == CH_EQUAL) begin
                     clear_v = 1'b1;
                     phase_in = PH_VSTART;
                  end else if (sp) begin
                     if (te_ff) begin
                        push = 1'b1;
                        push_rec.kind = KIND_ABORT;
                     end
                     te_in = 1'b0;
                     phase_in = PH_BETWEEN;
                  end else begin
                     push = 1'b1;
                     push_rec.kind = KIND_KEY;
                     push_rec.data = c;
                  end
               end
               PH_VSTART: begin
                  if (c == CH_QUOTE) begin
                     phase_in = PH_QUOTED;
                  end else if (sp) begin
                     pair = 1'b1;
                  end else begin
                     track = 1'b1;
                     phase_in = PH_UNQUOTED;
                  end
               end
               PH_UNQUOTED: begin
                  if (sp) begin
                     pair = 1'b1;
                  end else begin
                     track = 1'b1;
                  end
               end
               PH_QUOTED: begin
                  if (c == CH_QUOTE) begin
                     pair = 1'b1;
                  end else begin
                     if (c == CH_BSLASH) begin
                        phase_in = PH_QESC;
                     end
                     track = 1'b1;
                  end
               end
               PH_QESC: begin
                  track = 1'b1;
                  phase_in = PH_QUOTED;
               end
               PH_SKIP: begin
                  if (sp) begin
                     phase_in = PH_BETWEEN;
                  end
               end
               default: begin
                  if (sp) begin
                     phase_in = PH_BETWEEN;
                  end else if (c == CH_EQUAL) begin
                     phase_in = PH_SKIP;
                  end else begin
                     push = 1'b1;
                     push_rec.kind = KIND_KEY;
                     push_rec.data = c;
                     te_in = 1'b1;
                     phase_in = PH_KEY;
                  end
               end
            endcase
            if (track) begin
               push = 1'b1;
               push_rec.kind = KIND_VAL;
               push_rec.data = c;
            end
            if (pair) begin
               push = 1'b1;
               push_rec.kind = KIND_PAIR;
               push_rec.vtype = pe_type;
               push_rec.ival = pe_ival;
               cnt_in = cnt_inc;
               te_in = 1'b0;
               clear_v = 1'b1;
               phase_in = PH_BETWEEN;
            end
         end
      end

      np_in = np_ff;
      wm_in = wm_ff;
      acc_in = acc_ff;
      neg_in = neg_ff;
      sat_in = sat_ff;
      if (clear_v) begin
         np_in = NP_START;
         wm_in = WM_START;
         acc_in = 64'd0;
         neg_in = 1'b0;
         sat_in = 1'b0;
      end else if (track) begin
         np_in = tv_np;
         wm_in = tv_wm;
         acc_in = tv_acc;
         neg_in = tv_neg;
         sat_in = tv_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         np_ff <= NP_START;
         wm_ff <= WM_START;
         acc_ff <= 64'd0;
         neg_ff <= 1'b0;
         sat_ff <= 1'b0;
         te_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         np_ff <= np_in;
         wm_ff <= wm_in;
         acc_ff <= acc_in;
         neg_ff <= neg_in;
         sat_ff <= sat_in;
         te_ff <= te_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/lpt_queue.sv =====
module lpt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lpt_pkg::rec_type push_rec,
   output logic             full,
   input  logic             pop,
   output lpt_pkg::rec_type pop_rec,
   output logic             empty
);
   import lpt_pkg::*;

   rec_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_rec = mem_ff[rd_ff];

   always_comb begin
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/lpt_back.sv =====
module lpt_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   input  lpt_pkg::rec_type pop_rec,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [2:0]       out_kind,
   output logic [7:0]       out_data,
   output logic [2:0]       out_vtype,
   output logic [63:0]      out_ival,
   output logic [15:0]      out_count,
   output logic             out_last
);
   import lpt_pkg::*;

   logic        valid_ff, valid_in;
   logic        pend_ff, pend_in;
   logic [15:0] pend_count_ff, pend_count_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  data_ff, data_in;
   logic [2:0]  vtype_ff, vtype_in;
   logic [63:0] ival_ff, ival_in;
   logic [15:0] count_ff, count_in;
   logic        last_ff, last_in;
   logic        slot_free;

   assign slot_free = !valid_ff || out_ready;
   assign pop = slot_free && !pend_ff && !empty;

   always_comb begin
      valid_in = valid_ff;
      pend_in = pend_ff;
      pend_count_in = pend_count_ff;
      kind_in = kind_ff;
      data_in = data_ff;
      vtype_in = vtype_ff;
      ival_in = ival_ff;
      count_in = count_ff;
      last_in = last_ff;
      if (slot_free) begin
         valid_in = 1'b0;
         if (pend_ff) begin
            // second result of the entry: line end
            valid_in = 1'b1;
            pend_in = 1'b0;
            kind_in = KIND_LINE;
            data_in = 8'd0;
            vtype_in = VT_STRING;
            ival_in = 64'd0;
            count_in = pend_count_ff;
            last_in = 1'b1;
         end else if (!empty) begin
            valid_in = 1'b1;
            pend_in = pop_rec.two;
            pend_count_in = pop_rec.count;
            kind_in = pop_rec.kind;
            data_in = pop_rec.data;
            vtype_in = pop_rec.vtype;
            ival_in = pop_rec.ival;
            count_in = (pop_rec.kind == KIND_LINE) ? pop_rec.count : 16'd0;
            last_in = !pop_rec.two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_count_ff <= pend_count_in;
      kind_ff <= kind_in;
      data_ff <= data_in;
      vtype_ff <= vtype_in;
      ival_ff <= ival_in;
      count_ff <= count_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_kind = kind_ff;
   assign out_data = data_ff;
   assign out_vtype = vtype_ff;
   assign out_ival = ival_ff;
   assign out_count = count_ff;
   assign out_last = last_ff;

endmodule

// ===== rtl/logfmt_pair_tokenizer.sv =====
// A result is written into the queue when its byte is transferred, then moved into
// the output register, from which it is offered on rsp. Throughput: one byte per
// cycle while the queue is not full; the per-byte parse step and the decimal
// accumulate (shift-add times ten and limit compare) are combinational. A line end that
// closes an open pair or token yields two results; a 4-entry queue absorbs such bursts.
// Reset (synchronous, active high) clears parse state, pair count, queue, rsp_tvalid.
module logfmt_pair_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [7:0] data_byte, [10:8] value_type,
                                    // [74:11] int_value, [90:75] pair_count
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last
);
   import lpt_pkg::*;

   logic        push;
   rec_type     push_rec;
   logic        full;
   logic        pop;
   rec_type     pop_rec;
   logic        empty;
   logic [7:0]  out_data;
   logic [2:0]  out_vtype;
   logic [63:0] out_ival;
   logic [15:0] out_count;

   lpt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_ch       (req_tdata),
      .in_line_end (req_tlast),
      .push        (push),
      .push_rec    (push_rec),
      .full        (full)
   );

   lpt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .full     (full),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .empty    (empty)
   );

   lpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_rec   (pop_rec),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_data  (out_data),
      .out_vtype (out_vtype),
      .out_ival  (out_ival),
      .out_count (out_count),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, out_count, out_ival, out_vtype, out_data};

endmodule

// ===== rtl/lpt_checker.sv =====
`include "logfmt_pair_tokenizer_defines.svh"

module lpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import lpt_pkg::*;

   logic [99:0] rsp_all;
   logic        rsp_stall;
   logic        has_byte;

   assign rsp_all = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign has_byte = (rsp_tuser == KIND_KEY) || (rsp_tuser == KIND_VAL);

   // stalled transfer holds
   `LPT_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_all))

   // line end is always the last result of its byte
   `LPT_ASSERT_NOW(a_line_last, rsp_tvalid && rsp_tuser == KIND_LINE, rsp_tlast)

   // only key and value results carry a byte
   `LPT_ASSERT_NOW(a_byte_zero, rsp_tvalid && !has_byte, rsp_tdata[7:0] == 8'd0)

   // type and integer appear only at pair end
   `LPT_ASSERT_NOW(a_pair_only, rsp_tvalid && rsp_tuser != KIND_PAIR, rsp_tdata[74:8] == 67'd0)

   // nothing offered right after reset
   `LPT_ASSERT_NOW(a_reset_idle, $past(reset), !rsp_tvalid)

endmodule

bind logfmt_pair_tokenizer lpt_checker u_lpt_checker (.*);

// ===== test/logfmt_pair_tokenizer_tb.sv =====
module logfmt_pair_tokenizer_tb;
   import lpt_pkg::*;

   localparam int RANDOM_ITEMS = 950;
   localparam logic [15:0] PAIR_MAX = 16'((32'd1 << CNT_W) - 32'd1);

   typedef struct {
      kind_type    kind;
      logic [7:0]  data;
      logic [2:0]  vtype;
      logic [63:0] ival;
      logic [15:0] count;
      logic        last;
   } token_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] ch
   logic        req_tlast = 1'b0;    // line_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;           // [7:0] data_byte, [10:8] value_type,
                                     // [74:11] int_value, [90:75] pair_count
   logic [2:0]  rsp_tuser;           // [2:0] kind
   logic        rsp_tlast;           // last

   logfmt_pair_tokenizer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3000000;
      $display("Simulation FAILED");
      $finish;
   end

   // tokenizer state as seen from outside
   phase_type     tok_phase;
   num_phase_type num_phase;
   logic [3:0]    word_pos;
   logic [63:0]   mag;
   logic          mag_neg;
   logic          mag_sat;
   logic          key_open;
   logic [15:0]   pairs_in_line;

   token_result_type pending_results[$];
   token_result_type item_results[$];
   token_result_type oldest;
   logic [7:0]    line_buf[$];
   logic [7:0]    val_buf[$];

   int error_count = 0;
   int items_sent = 0;
   int burst_left = 0;

   string true_word = "true";
   string false_word = "false";
   string limit_nums [8] = '{"9223372036854775807", "9223372036854775808",
                             "-9223372036854775808", "-9223372036854775809",
                             "184467440737095516160", "0", "-0", "000123"};
   string word_forms [9] = '{"true", "false", "tru", "truex", "fals", "falsee",
                             "True", "t", "f"};
   string bad_nums [10] = '{"-", "-.5", "1e", "1.5x", "1e+", "--1", "1.2.3", "+5",
                            "1e5e", "2.5e-7"};

   function automatic bit is_blank(input logic [7:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic bit is_decimal(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic void add_result(input kind_type kind, input logic [7:0] data,
                                      input logic [2:0] vtype, input logic [63:0] ival,
                                      input logic [15:0] count);
      token_result_type r;
      r.kind = kind;
      r.data = data;
      r.vtype = vtype;
      r.ival = ival;
      r.count = count;
      r.last = 1'b0;
      item_results.push_back(r);
   endfunction

   function automatic void clear_number();
      num_phase = NP_START;
      word_pos = WM_START;
      mag = 64'd0;
      mag_neg = 1'b0;
      mag_sat = 1'b0;
   endfunction

   function automatic void reset_parser();
      tok_phase = PH_BETWEEN;
      clear_number();
      key_open = 1'b0;
      pairs_in_line = 16'd0;
   endfunction

   // decimal accumulate, pinned at the limit of the sign once it overflows
   function automatic void add_digit(input logic [7:0] c);
      logic [63:0] d;
      logic [63:0] lim;
      d = {56'd0, c - 8'h30};
      lim = mag_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (!mag_sat) begin
         if (mag > (lim - d) / 64'd10) begin
            mag = lim;
            mag_sat = 1'b1;
         end else begin
            mag = mag * 64'd10 + d;
         end
      end
   endfunction

   function automatic void classify_byte(input logic [7:0] c);
      bit is_exp;
      is_exp = (c == CH_LOWER_E) || (c == CH_UPPER_E);
      case (num_phase)
         NP_START: begin
            if (c == CH_MINUS) begin
               mag_neg = 1'b1;
               num_phase = NP_SIGN;
            end else if (is_decimal(c)) begin
               add_digit(c);
               num_phase = NP_INT;
            end else begin
               num_phase = NP_NOT;
            end
         end
         NP_SIGN: begin
            if (is_decimal(c)) begin
               add_digit(c);
               num_phase = NP_INT;
            end else begin
               num_phase = NP_NOT;
            end
         end
         NP_INT: begin
            if (is_decimal(c)) add_digit(c);
            else if (c == CH_DOT) num_phase = NP_FRAC;
            else if (is_exp) num_phase = NP_EXPM;
            else num_phase = NP_NOT;
         end
         NP_FRAC: begin
            if (is_exp) num_phase = NP_EXPM;
            else if (!is_decimal(c)) num_phase = NP_NOT;
         end
         NP_EXPM: begin
            if ((c == CH_PLUS) || (c == CH_MINUS)) num_phase = NP_EXPS;
            else if (is_decimal(c)) num_phase = NP_EXPD;
            else num_phase = NP_NOT;
         end
         NP_EXPS, NP_EXPD: begin
            num_phase = is_decimal(c) ? NP_EXPD : NP_NOT;
         end
         default: num_phase = NP_NOT;
      endcase

      if (word_pos == WM_START) begin
         word_pos = (c == CH_LOWER_T) ? 4'd1 : (c == CH_LOWER_F) ? WM_FALSE_FIRST : WM_NONE;
      end else if ((word_pos >= 4'd1) && (word_pos < WM_TRUE)) begin
         word_pos = (c == 8'(true_word[word_pos])) ? word_pos + 4'd1 : WM_NONE;
      end else if ((word_pos >= WM_FALSE_FIRST) && (word_pos < WM_FALSE)) begin
         word_pos = (c == 8'(false_word[word_pos - WM_TRUE])) ? word_pos + 4'd1 : WM_NONE;
      end else begin
         word_pos = WM_NONE;
      end
   endfunction

   function automatic void close_pair();
      logic [2:0]  vt;
      logic [63:0] iv;
      vt = VT_STRING;
      iv = 64'd0;
      if (num_phase == NP_INT) begin
         vt = VT_INTEGER;
         iv = mag_neg ? 64'd0 - mag : mag;
      end else if ((num_phase == NP_FRAC) || (num_phase == NP_EXPD)) begin
         vt = VT_FLOAT;
      end else if (word_pos == WM_TRUE) begin
         vt = VT_TRUE;
      end else if (word_pos == WM_FALSE) begin
         vt = VT_FALSE;
      end
      add_result(KIND_PAIR, 8'h00, vt, iv, 16'd0);
      if (pairs_in_line != PAIR_MAX) pairs_in_line = pairs_in_line + 16'd1;
      key_open = 1'b0;
      clear_number();
      tok_phase = PH_BETWEEN;
   endfunction

   function automatic void value_byte(input logic [7:0] c);
      classify_byte(c);
      add_result(KIND_VAL, c, VT_STRING, 64'd0, 16'd0);
   endfunction

   // work out the results of one accepted byte and queue them
   function automatic void tokenize_byte(input logic [7:0] c, input logic eol);
      token_result_type r;
      bit sp;
      item_results.delete();
      sp = is_blank(c);
      if (eol || (c == 8'h00)) begin
         case (tok_phase)
            PH_KEY, PH_QUOTED, PH_QESC: begin
               if (key_open) add_result(KIND_ABORT, 8'h00, VT_STRING, 64'd0, 16'd0);
            end
            PH_VSTART, PH_UNQUOTED: close_pair();
            default: ;
         endcase
         add_result(KIND_LINE, 8'h00, VT_STRING, 64'd0, pairs_in_line);
         reset_parser();
      end else begin
         case (tok_phase)
            PH_KEY: begin
               if (c == CH_EQUAL) begin
                  clear_number();
                  tok_phase = PH_VSTART;
               end else if (sp) begin
                  if (key_open) add_result(KIND_ABORT, 8'h00, VT_STRING, 64'd0, 16'd0);
                  key_open = 1'b0;
                  tok_phase = PH_BETWEEN;
               end else begin
                  add_result(KIND_KEY, c, VT_STRING, 64'd0, 16'd0);
               end
            end
            PH_VSTART: begin
               if (c == CH_QUOTE) begin
                  tok_phase = PH_QUOTED;
               end else if (sp) begin
                  close_pair();
               end else begin
                  value_byte(c);
                  tok_phase = PH_UNQUOTED;
               end
            end
            PH_UNQUOTED: begin
               if (sp) close_pair();
               else value_byte(c);
            end
            PH_QUOTED: begin
               if (c == CH_QUOTE) begin
                  close_pair();
               end else begin
                  if (c == CH_BSLASH) tok_phase = PH_QESC;
                  value_byte(c);
               end
            end
            PH_QESC: begin
               value_byte(c);
               tok_phase = PH_QUOTED;
            end
            PH_SKIP: begin
               if (sp) tok_phase = PH_BETWEEN;
            end
            default: begin
               if (sp) begin
                  tok_phase = PH_BETWEEN;
               end else if (c == CH_EQUAL) begin
                  tok_phase = PH_SKIP;
               end else begin
                  add_result(KIND_KEY, c, VT_STRING, 64'd0, 16'd0);
                  key_open = 1'b1;
                  tok_phase = PH_KEY;
               end
            end
         endcase
      end
      for (int i = 0; i < item_results.size(); i++) begin
         r = item_results[i];
         r.last = (i == item_results.size() - 1);
         pending_results.push_back(r);
      end
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want_v,
                                       input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0d tdata %0h",
                     $time, rsp_tuser, rsp_tdata);
            error_count++;
         end else begin
            oldest = pending_results.pop_front();
            check_field("kind", 64'(oldest.kind), 64'(rsp_tuser));
            check_field("data_byte", 64'(oldest.data), 64'(rsp_tdata[7:0]));
            check_field("value_type", 64'(oldest.vtype), 64'(rsp_tdata[10:8]));
            check_field("int_value", oldest.ival, rsp_tdata[74:11]);
            check_field("pair_count", 64'(oldest.count), 64'(rsp_tdata[90:75]));
            check_field("last", 64'(oldest.last), 64'(rsp_tlast));
         end
      end
   end

   // result side backpressure: switch between ready patterns after runs of random length
   int   sink_mode = 0;
   int   sink_left = 0;
   int   sink_run = 0;
   logic sink_level = 1'b0;

   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode = $urandom_range(0, 3);
         sink_left = $urandom_range(50, 400);
      end
      sink_left--;
      case (sink_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= 1'($urandom_range(0, 1));
         default: begin
            if (sink_run == 0) begin
               sink_level = !sink_level;
               sink_run = sink_level ? $urandom_range(1, 6) : $urandom_range(1, 12);
            end
            sink_run--;
            rsp_tready <= sink_level;
         end
      endcase
   end

   task automatic push_item(input logic [7:0] c, input logic eol);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= eol;
      do @(posedge clock); while (!req_tready);
      tokenize_byte(c, eol);
      items_sent++;
      burst_left--;
   endtask

   task automatic send_line(input logic [7:0] term_ch, input logic term_eol);
      foreach (line_buf[i]) push_item(line_buf[i], 1'b0);
      push_item(term_ch, term_eol);
      line_buf.delete();
   endtask

   // hold off the sender until every queued result has been checked
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(8'(s[i]));
   endfunction

   function automatic void put_value_text(input string s);
      for (int i = 0; i < s.len(); i++) val_buf.push_back(8'(s[i]));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_blank();
      return ($urandom_range(0, 1) == 0) ? 8'd32 : 8'($urandom_range(9, 13));
   endfunction

   function automatic logic [7:0] rand_word_byte();
      logic [7:0] b;
      if ($urandom_range(0, 9) < 7) return 8'($urandom_range(33, 126));
      do b = 8'($urandom_range(1, 255)); while (is_blank(b));
      return b;
   endfunction

   function automatic logic [7:0] rand_key_byte();
      logic [7:0] b;
      if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h61, 8'h7A));
      do b = 8'($urandom_range(1, 255)); while (is_blank(b) || (b == CH_EQUAL));
      return b;
   endfunction

   function automatic void add_key();
      repeat ($urandom_range(1, 4)) line_buf.push_back(rand_key_byte());
   endfunction

   function automatic void gen_value();
      int cls;
      val_buf.delete();
      cls = $urandom_range(0, 6);
      case (cls)
         0: begin
            if ($urandom_range(0, 1) == 1) val_buf.push_back(CH_MINUS);
            repeat ($urandom_range(1, 19)) val_buf.push_back(rand_digit());
         end
         1: put_value_text(limit_nums[$urandom_range(0, 7)]);
         2: begin
            if ($urandom_range(0, 2) == 0) val_buf.push_back(CH_MINUS);
            repeat ($urandom_range(1, 5)) val_buf.push_back(rand_digit());
            if ($urandom_range(0, 2) != 1) begin
               val_buf.push_back(CH_DOT);
               repeat ($urandom_range(0, 4)) val_buf.push_back(rand_digit());
            end
            if ($urandom_range(0, 2) != 0) begin
               val_buf.push_back(($urandom_range(0, 1) == 1) ? CH_LOWER_E : CH_UPPER_E);
               case ($urandom_range(0, 2))
                  0: val_buf.push_back(CH_PLUS);
                  1: val_buf.push_back(CH_MINUS);
                  default: ;
               endcase
               repeat ($urandom_range(1, 3)) val_buf.push_back(rand_digit());
            end
         end
         3: put_value_text(word_forms[$urandom_range(0, 8)]);
         4: put_value_text(bad_nums[$urandom_range(0, 9)]);
         5: repeat ($urandom_range(1, 8)) val_buf.push_back(rand_word_byte());
         default: ;
      endcase
   endfunction

   // key=value with random content; returns 1 when the value was quoted
   function automatic bit add_pair();
      bit quoted;
      add_key();
      line_buf.push_back(CH_EQUAL);
      gen_value();
      quoted = ($urandom_range(0, 9) < 3);
      if (quoted) begin
         line_buf.push_back(CH_QUOTE);
         if ($urandom_range(0, 3) == 0) line_buf.push_back(8'd32);
         foreach (val_buf[i]) begin
            if ((val_buf[i] == CH_QUOTE) || (val_buf[i] == CH_BSLASH) ||
                ($urandom_range(0, 15) == 0))
               line_buf.push_back(CH_BSLASH);
            line_buf.push_back(val_buf[i]);
         end
         line_buf.push_back(CH_QUOTE);
      end else begin
         foreach (val_buf[i]) line_buf.push_back(val_buf[i]);
      end
      return quoted;
   endfunction

   // leave a token open when the line ends
   function automatic void add_open_tail();
      case ($urandom_range(0, 3))
         0: begin
            add_key();
            line_buf.push_back(CH_EQUAL);
            line_buf.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 3)) line_buf.push_back(rand_word_byte());
         end
         1: begin
            add_key();
            line_buf.push_back(CH_EQUAL);
            line_buf.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 2)) line_buf.push_back(rand_word_byte());
            line_buf.push_back(CH_BSLASH);
         end
         2: add_key();
         default: begin
            add_key();
            line_buf.push_back(CH_EQUAL);
            repeat ($urandom_range(0, 3)) line_buf.push_back(rand_digit());
         end
      endcase
   endfunction

   // skipped '=' token, key dropped by whitespace, key dropped by line end
   task automatic test_skip_and_abort();
      add_text("=x\tk\vj");
      send_line(8'hFF, 1'b1);
   endtask

   // empty value, escaped quote, new key right after the closing quote, true
   task automatic test_value_forms();
      add_text("e= q=\"\\\"\"t=true");
      send_line(8'h00, 1'b1);
   endtask

   // open quote closed by a zero byte, then high bytes up to a flagged line end
   task automatic test_line_terminators();
      add_text("n=\"5");
      send_line(8'h00, 1'b0);
      line_buf.push_back(8'hFF);
      line_buf.push_back(CH_EQUAL);
      line_buf.push_back(8'h80);
      send_line(8'h41, 1'b1);
   endtask

   task automatic test_random_lines();
      int  start;
      int  n_tok;
      int  roll;
      int  line_no;
      bit  quoted;
      start = items_sent;
      line_no = 0;
      while (items_sent - start < RANDOM_ITEMS) begin
         line_buf.delete();
         n_tok = $urandom_range(0, 5);
         for (int t = 0; t < n_tok; t++) begin
            roll = $urandom_range(0, 99);
            quoted = 1'b0;
            if (roll < 70) begin
               quoted = add_pair();
            end else if (roll < 78) begin
               line_buf.push_back(CH_EQUAL);
               repeat ($urandom_range(0, 3)) line_buf.push_back(rand_key_byte());
            end else if (roll < 88) begin
               add_key();
            end else begin
               repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(1, 255)));
            end
            if (!(quoted && ($urandom_range(0, 2) == 0)) &&
                !((t == n_tok - 1) && ($urandom_range(0, 1) == 1)))
               repeat ($urandom_range(1, 2)) line_buf.push_back(rand_blank());
         end
         roll = $urandom_range(0, 99);
         if (roll < 20) add_open_tail();
         if (roll >= 85) send_line(8'h00, 1'b0);
         else send_line(8'($urandom_range(0, 255)), 1'b1);
         line_no++;
         if (line_no % 8 == 1) wait_drained();
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int waited;
      reset_parser();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_skip_and_abort();
      test_value_forms();
      test_line_terminators();
      test_random_lines();
      waited = 0;
      while ((pending_results.size() != 0) && (waited < 50000)) begin
         @(posedge clock);
         waited++;
      end
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results still expected, none arrived", $time,
                  pending_results.size());
         error_count++;
      end
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
